FILE: src/lte_pkg.sv
// ----------------------------------------------------------------------------
// lte_pkg: shared types and constants for the text byte escaper
// Item layouts, escape kinds, register indexes and the tables that
// spell out each escape sequence one byte at a time.
// ----------------------------------------------------------------------------
package lte_pkg;

  // Default depth of the queue between the classifier and the sequencer.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_CHAR = 2'd1;

  localparam logic [7:0] ESCAPE_CHAR_RESET = 8'h22;

  // Character codes used by the escape sequences.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LESS    = 8'h3c;
  localparam logic [7:0] CH_GREATER = 8'h3e;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_Q       = 8'h71;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_O       = 8'h6f;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_G       = 8'h67;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LESS10 = 8'h57;

  typedef enum logic [1:0] {
    MODE_BACKSLASH = 2'd0,
    MODE_XML_ATTR  = 2'd1,
    MODE_XML_TEXT  = 2'd2,
    MODE_RAW       = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_PASS    = 3'd0,
    KIND_BS_CHAR = 3'd1,
    KIND_BS_HEX  = 3'd2,
    KIND_XML_HEX = 3'd3,
    KIND_QUOT    = 3'd4,
    KIND_LT      = 3'd5,
    KIND_GT      = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       seq_last;
    logic       text_done;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_byte;
    logic       text_end;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] step;
  } back_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    return (v < 4'd10) ? (CH_ZERO + w) : (CH_A_LESS10 + w);
  endfunction

  // Number of output bytes for each kind of escape.
  function automatic logic [2:0] seq_len(input kind_t kind);
    logic [2:0] n;
    case (kind)
      KIND_PASS:    n = 3'd1;
      KIND_BS_CHAR: n = 3'd2;
      KIND_BS_HEX:  n = 3'd4;
      KIND_XML_HEX: n = 3'd6;
      KIND_QUOT:    n = 3'd6;
      KIND_LT:      n = 3'd4;
      KIND_GT:      n = 3'd4;
      default:      n = 3'd1;
    endcase
    return n;
  endfunction

  // Byte number step of the escape sequence for byte b.
  function automatic logic [7:0] seq_byte(input kind_t kind, input logic [7:0] b,
                                          input logic [2:0] step);
    logic [7:0] c;
    case (kind)
      KIND_BS_CHAR: c = (step == 3'd0) ? CH_BSLASH : b;
      KIND_BS_HEX: begin
        case (step)
          3'd0:    c = CH_BSLASH;
          3'd1:    c = CH_X;
          3'd2:    c = hex_digit(b[7:4]);
          default: c = hex_digit(b[3:0]);
        endcase
      end
      KIND_XML_HEX: begin
        case (step)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_HASH;
          3'd2:    c = CH_X;
          3'd3:    c = hex_digit(b[7:4]);
          3'd4:    c = hex_digit(b[3:0]);
          default: c = CH_SEMI;
        endcase
      end
      KIND_QUOT: begin
        case (step)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_Q;
          3'd2:    c = CH_U;
          3'd3:    c = CH_O;
          3'd4:    c = CH_T;
          default: c = CH_SEMI;
        endcase
      end
      KIND_LT: begin
        case (step)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_L;
          3'd2:    c = CH_T;
          default: c = CH_SEMI;
        endcase
      end
      KIND_GT: begin
        case (step)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_G;
          3'd2:    c = CH_T;
          default: c = CH_SEMI;
        endcase
      end
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

FILE: src/lte_front.sv
// ----------------------------------------------------------------------------
// lte_front: configuration registers and byte classifier
// Holds the escape mode and escape character, sorts each accepted byte
// into an escape kind and writes it to the queue.
// ----------------------------------------------------------------------------
module lte_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lte_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lte_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  lte_pkg::in_item_t                   in_item,
  input  lte_pkg::q_status_t                  q_st,
  output logic                                in_stall,
  output logic                                push,
  output lte_pkg::q_entry_t                   push_entry
);
  import lte_pkg::*;

  mode_t      escape_mode_r, escape_mode_nxt;
  logic [7:0] escape_char_r, escape_char_nxt;
  kind_t      kind;
  logic [7:0] b;
  logic       is_ctrl;

  always_comb begin
    escape_mode_nxt = escape_mode_r;
    escape_char_nxt = escape_char_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ESCAPE_MODE: escape_mode_nxt = mode_t'(cfg_data[1:0]);
        CFG_ESCAPE_CHAR: escape_char_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_mode_r <= MODE_BACKSLASH;
      escape_char_r <= ESCAPE_CHAR_RESET;
    end else begin
      escape_mode_r <= escape_mode_nxt;
      escape_char_r <= escape_char_nxt;
    end
  end

  assign b       = in_item.text_byte;
  assign is_ctrl = (b < CH_SPACE);

  // In backslash mode the control escape takes priority over the escape
  // character, and tab is left alone unless it is the escape character.
  always_comb begin
    case (escape_mode_r)
      MODE_BACKSLASH: begin
        if (is_ctrl && (b != CH_TAB)) kind = KIND_BS_HEX;
        else if (b == escape_char_r)  kind = KIND_BS_CHAR;
        else                          kind = KIND_PASS;
      end
      MODE_XML_ATTR: begin
        if (is_ctrl)             kind = KIND_XML_HEX;
        else if (b == CH_QUOTE)  kind = KIND_QUOT;
        else                     kind = KIND_PASS;
      end
      MODE_XML_TEXT: begin
        if (is_ctrl)               kind = KIND_XML_HEX;
        else if (b == CH_LESS)     kind = KIND_LT;
        else if (b == CH_GREATER)  kind = KIND_GT;
        else                       kind = KIND_PASS;
      end
      default: kind = KIND_PASS;
    endcase
  end

  assign in_stall             = q_st.full;
  assign push                 = in_valid && !q_st.full;
  assign push_entry.kind      = kind;
  assign push_entry.text_byte = b;
  assign push_entry.text_end  = in_item.text_end;

endmodule

FILE: src/lte_queue.sv
// ----------------------------------------------------------------------------
// lte_queue: short queue of classified items
// Register-based first-in first-out buffer between classifier and sequencer.
// ----------------------------------------------------------------------------
module lte_queue #(
  parameter int DEPTH = lte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lte_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output lte_pkg::q_entry_t  head,
  output lte_pkg::q_status_t q_st
);
  import lte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign q_st.full  = (count_r == CNT_W'(DEPTH));
  assign q_st.empty = (count_r == '0);

endmodule

FILE: src/lte_back.sv
// ----------------------------------------------------------------------------
// lte_back: escape sequencer and output register
// Walks the item at the head of the queue one output byte per cycle while
// the output is not stalled and releases it from the queue with its last byte.
// ----------------------------------------------------------------------------
module lte_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lte_pkg::q_entry_t    head,
  input  lte_pkg::q_status_t   q_st,
  input  logic                 out_stall,
  output logic                 pop,
  output logic                 out_valid,
  output lte_pkg::out_item_t   out_item,
  output lte_pkg::back_status_t back_st
);
  import lte_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       load;
  logic       last;

  assign load = !out_valid_r || !out_stall;
  assign last = (step_r == seq_len(head.kind) - 3'd1);
  assign pop  = load && !q_st.empty && last;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt          = !q_st.empty;
      out_item_nxt.out_byte  = seq_byte(head.kind, head.text_byte, step_r);
      out_item_nxt.seq_last  = last;
      out_item_nxt.text_done = last && head.text_end;
      if (!q_st.empty) begin
        step_nxt = last ? 3'd0 : step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign back_st.busy = out_valid_r;
  assign back_st.step = step_r;

endmodule

FILE: src/log_text_byte_escaper.sv
// ----------------------------------------------------------------------------
// log_text_byte_escaper: escapes a text stream for log output
// Each input item is one text byte; it leaves as one to six output bytes in
// backslash, XML attribute, XML text or raw form, the last byte marked.
// ----------------------------------------------------------------------------
// The block produces exactly one output byte per clock cycle while an item
// is queued and the output side is not stalled. The escaped form of an
// input item has one byte for a byte that passes through, two for a
// backslashed escape character, four for a \xhh, &lt; or &gt; sequence and
// six for &#xhh; or &quot;. The package function seq_len gives these lengths.
// A queue of QUEUE_DEPTH items sits between the classifier and the
// sequencer, so input items keep being taken on consecutive cycles until
// the queue fills. When the queue is empty and the output register is free,
// an accepted item is written to a queue entry and its first byte is then
// loaded into the output register. Configuration is sampled by the
// classifier, so it should only be written while no item is in flight.
module log_text_byte_escaper #(
  parameter int QUEUE_DEPTH = lte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lte_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lte_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lte_pkg::out_item_t              out_item
);
  import lte_pkg::*;

  logic         push;
  logic         pop;
  q_entry_t     push_entry;
  q_entry_t     head;
  q_status_t    q_st;
  back_status_t back_st;

  // Front part: registers and classification of each accepted item.
  lte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .q_st       (q_st),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue lets the input keep flowing while a long sequence is emitted.
  lte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_st       (q_st)
  );

  // Back part: spells out the escape sequence of the item at the head.
  lte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_st      (q_st),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .back_st   (back_st)
  );

  // The end-of-text mark can only sit on the last byte of a sequence.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.text_done) |-> out_item.seq_last)
    else $error("text_done without seq_last");

  // The sequencer is only part-way through a sequence while its item is queued.
  a_step_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (back_st.step != 3'd0) |-> !q_st.empty)
    else $error("sequence step with empty queue");

  // A queued item and a free output register always give an output byte.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_st.empty && (!back_st.busy || !out_stall)) |=> out_valid)
    else $error("sequencer failed to emit");

endmodule
